// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the executor block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MOAE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define MOAE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/moae_pkg.sv -----
// ----------------------------------------------------------------------------
// moae_pkg
// Operation and status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package moae_pkg;

    // Stream widths (fixed by the instruction and result formats).
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Operation codes.
    localparam logic [3:0] OP_TRAP  = 4'd0;
    localparam logic [3:0] OP_NOP   = 4'd1;
    localparam logic [3:0] OP_EXIT  = 4'd2;
    localparam logic [3:0] OP_PANIC = 4'd3;
    localparam logic [3:0] OP_HALT  = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd5;
    localparam logic [3:0] OP_SUB   = 4'd6;
    localparam logic [3:0] OP_MUL   = 4'd7;
    localparam logic [3:0] OP_DIV   = 4'd8;
    localparam logic [3:0] OP_AND   = 4'd9;
    localparam logic [3:0] OP_OR    = 4'd10;
    localparam logic [3:0] OP_XOR   = 4'd11;
    localparam logic [3:0] OP_NOT   = 4'd12;
    localparam logic [3:0] OP_MOV   = 4'd13;
    // Unassigned code; it behaves like nop.
    localparam logic [3:0] OP_SPARE = 4'd14;
    localparam logic [3:0] OP_END   = 4'd15;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TRAP    = 3'd1;
    localparam logic [2:0] ST_EXIT    = 3'd2;
    localparam logic [2:0] ST_PANIC   = 3'd3;
    localparam logic [2:0] ST_HALT    = 3'd4;
    localparam logic [2:0] ST_DIVZERO = 3'd5;
    localparam logic [2:0] ST_BADADDR = 3'd6;
    localparam logic [2:0] ST_STOPPED = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_WAIT,
        S_DONE
    } t_state;

    // Control from the sequencer to the iterative unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_iter_ctl;

endpackage

// ----- design/moae_ram.sv -----
// ----------------------------------------------------------------------------
// moae_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module moae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/moae_iter.sv -----
// ----------------------------------------------------------------------------
// moae_iter
// Bit-serial multiply and signed divide sharing one adder/subtractor.
// ----------------------------------------------------------------------------
module moae_iter #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  moae_pkg::t_iter_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);
    import moae_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_count;
    logic          r_is_div;
    logic          r_neg;
    logic [W-1:0]  r_acc;   // product or partial remainder
    logic [W-1:0]  r_x;     // multiplicand or divisor
    logic [W-1:0]  r_y;     // multiplier or dividend/quotient

    logic [W-1:0]  a_abs;
    logic [W-1:0]  b_abs;
    logic [W:0]    add_op1;
    logic [W:0]    add_op2;
    logic [W:0]    add_sum;
    logic          q_bit;

    assign a_abs = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign b_abs = i_b[W-1] ? (W'(0) - i_b) : i_b;

    // Shared adder: accumulate for multiply, trial subtract for divide.
    always_comb begin
        if (r_is_div) begin
            add_op1 = {r_acc, r_y[W-1]};
            add_op2 = ~{1'b0, r_x};
        end else begin
            add_op1 = {1'b0, r_acc};
            add_op2 = r_y[0] ? {1'b0, r_x} : '0;
        end
        add_sum = add_op1 + add_op2 + {{W{1'b0}}, r_is_div};
        q_bit   = ~add_sum[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_count <= CW'(W);
            end else if (r_busy) begin
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_is_div <= i_ctl.is_div;
            r_neg    <= i_a[W-1] ^ i_b[W-1];
            r_acc    <= '0;
            if (i_ctl.is_div) begin
                r_x <= b_abs;
                r_y <= a_abs;
            end else begin
                r_x <= i_a;
                r_y <= i_b;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                r_acc <= q_bit ? add_sum[W-1:0] : add_op1[W-1:0];
                r_y   <= {r_y[W-2:0], q_bit};
            end else begin
                r_acc <= add_sum[W-1:0];
                r_x   <= {r_x[W-2:0], 1'b0};
                r_y   <= {1'b0, r_y[W-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = !r_is_div ? r_acc : (r_neg ? (W'(0) - r_y) : r_y);

endmodule

// ----- design/memory_operand_alu_executor_top.sv -----
// ----------------------------------------------------------------------------
// memory_operand_alu_executor_top
// Executes decoded instructions against a word-addressed data memory.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Bus fields (low bit first)
//  --------  ---  ---------------------------------------------------------
//  s_*       in   tdata: operation, operand_a, operand_b, dest_address
//                 tuser: a_indirect, b_indirect
//  m_*       out  tdata: status, result_value     tuser: wrote
//
//  After reset the data memory is cleared one word per cycle; no instruction
//  is taken during that pass. Control codes (trap, exit, halt, nop, ...) and
//  rejected instructions go straight to the final step. For an ALU
//  instruction the memory has a single read port, so operands A and B are
//  read one after the other. Multiply and divide run on a bit-serial unit.
//  Ready is high only while the sequencer is idle; a result waiting on a stalled
//  output holds the sequencer in its final step until the transfer completes.
//
`include "assert_macros.svh"

module memory_operand_alu_executor_top #(
    parameter int MEMORY_WORDS = 512,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // operation[3:0], operand_a[35:4], operand_b[67:36], dest_address[76:68]
    input  logic [moae_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // a_indirect[0], b_indirect[1]
    input  logic [moae_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // status[2:0], result_value[34:3]
    output logic [moae_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // wrote[0]
    output logic [moae_pkg::M_TUSER_W-1:0]   o_m_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready
);
    import moae_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int W  = DATA_WIDTH;

    // Sign-extend a 32-bit immediate and cut it to the data width.
    function automatic logic [W-1:0] imm_word(input logic [31:0] v);
        logic [63:0] sx;
        sx = 64'(signed'(v));
        return sx[W-1:0];
    endfunction

    // Incoming fields.
    logic [3:0]  s_op;
    logic [31:0] s_opa;
    logic [31:0] s_opb;
    logic [8:0]  s_dest;
    logic        s_ai;
    logic        s_bi;

    assign s_op   = i_s_tdata[3:0];
    assign s_opa  = i_s_tdata[35:4];
    assign s_opb  = i_s_tdata[67:36];
    assign s_dest = i_s_tdata[76:68];
    assign s_ai   = i_s_tuser[0];
    assign s_bi   = i_s_tuser[1];

    // Sequencer and instruction registers.
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_stopped;
    logic [3:0]    r_op;
    logic [31:0]   r_opa;
    logic [31:0]   r_opb;
    logic [31:0]   r_dest;
    logic          r_ai;
    logic          r_bi;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_res;
    logic [2:0]    r_status;
    logic          r_wrote;

    // Output register.
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [31:0]   r_out_value;
    logic          r_out_wrote;

    logic          s_accept;
    logic          out_free;
    logic [2:0]    acc_status;
    logic          acc_stop;
    logic          acc_arith;
    logic          acc_unary;
    logic          acc_bad;
    logic          go_exec;

    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;

    logic [W-1:0]  b_val;
    logic [W-1:0]  alu_res;
    logic          b_zero;
    logic          need_iter;
    t_iter_ctl     iter_ctl;
    logic          iter_done;
    logic [W-1:0]  iter_result;
    logic [63:0]   res_ext;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // Decode at accept time: control codes and address checks finish here.
    always_comb begin
        acc_status = ST_OK;
        acc_stop   = 1'b0;
        acc_arith  = 1'b0;
        case (s_op)
            OP_TRAP: begin
                acc_status = ST_TRAP;
                acc_stop   = 1'b1;
            end
            OP_EXIT, OP_END: begin
                acc_status = ST_EXIT;
                acc_stop   = 1'b1;
            end
            OP_PANIC: begin
                acc_status = ST_PANIC;
                acc_stop   = 1'b1;
            end
            OP_HALT: begin
                acc_status = ST_HALT;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_MOV: begin
                acc_arith = 1'b1;
            end
            default: begin
                acc_status = ST_OK;
            end
        endcase
        acc_unary = (s_op == OP_NOT) || (s_op == OP_MOV);
        // A negative source address reads as a huge unsigned value.
        acc_bad = (s_ai && (s_opa >= 32'(MEMORY_WORDS)))
               || (!acc_unary && s_bi && (s_opb >= 32'(MEMORY_WORDS)))
               || (32'(s_dest) >= 32'(MEMORY_WORDS));
        if (acc_arith && acc_bad) begin
            acc_status = ST_BADADDR;
        end
        if (r_stopped) begin
            acc_status = ST_STOPPED;
        end
        go_exec = !r_stopped && acc_arith && !acc_bad;
    end

    // Execute step: operand B arrives from the RAM in this cycle.
    always_comb begin
        b_val  = r_bi ? ram_rdata : imm_word(r_opb);
        b_zero = (b_val == '0);
        case (r_op)
            OP_ADD:  alu_res = r_a + b_val;
            OP_SUB:  alu_res = r_a - b_val;
            OP_AND:  alu_res = r_a & b_val;
            OP_OR:   alu_res = r_a | b_val;
            OP_XOR:  alu_res = r_a ^ b_val;
            OP_NOT:  alu_res = ~r_a;
            default: alu_res = r_a;
        endcase
        need_iter = (r_op == OP_MUL) || ((r_op == OP_DIV) && !b_zero);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MEMORY_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = go_exec ? S_RD_A : S_DONE;
                end
            end
            S_RD_A: n_state = S_RD_B;
            S_RD_B: n_state = S_EXEC;
            S_EXEC: n_state = need_iter ? S_WAIT : S_DONE;
            S_WAIT: begin
                if (iter_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Sequencer outputs: handshake, RAM ports and unit control.
    always_comb begin
        o_s_tready      = 1'b0;
        ram_raddr       = r_opb[AW-1:0];
        ram_we          = 1'b0;
        ram_waddr       = r_dest[AW-1:0];
        ram_wdata       = alu_res;
        iter_ctl.start  = 1'b0;
        iter_ctl.is_div = (r_op == OP_DIV);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: o_s_tready = 1'b1;
            S_RD_A: ram_raddr = r_opa[AW-1:0];
            S_EXEC: begin
                iter_ctl.start = need_iter;
                ram_we         = !need_iter && (r_op != OP_DIV);
            end
            S_WAIT: begin
                ram_we    = iter_done;
                ram_wdata = iter_result;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (s_accept && acc_stop) begin
                r_stopped <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Instruction and result payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op     <= s_op;
            r_opa    <= s_opa;
            r_opb    <= s_opb;
            r_dest   <= 32'(s_dest);
            r_ai     <= s_ai;
            r_bi     <= s_bi;
            r_status <= acc_status;
            r_wrote  <= 1'b0;
            r_res    <= '0;
        end
        if (r_state == S_RD_B) begin
            r_a <= r_ai ? ram_rdata : imm_word(r_opa);
        end
        if (r_state == S_EXEC) begin
            if ((r_op == OP_DIV) && b_zero) begin
                r_status <= ST_DIVZERO;
            end else if (!need_iter) begin
                r_res   <= alu_res;
                r_wrote <= 1'b1;
            end
        end
        if (r_state == S_WAIT && iter_done) begin
            r_res   <= iter_result;
            r_wrote <= 1'b1;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_value  <= r_wrote ? res_ext[31:0] : 32'd0;
            r_out_wrote  <= r_wrote;
        end
    end

    assign res_ext = 64'(r_res);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_value, r_out_status};
    assign o_m_tuser  = r_out_wrote;

    moae_ram #(
        .WIDTH (W),
        .DEPTH (MEMORY_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    moae_iter #(
        .DATA_WIDTH (W)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (iter_ctl),
        .i_a      (r_a),
        .i_b      (b_val),
        .o_done   (iter_done),
        .o_result (iter_result)
    );

    // Memory is only written while clearing, executing or retiring a unit result.
    `MOAE_NEVER(a_no_idle_write, i_clk, i_rst_n, ram_we && (r_state == S_IDLE || r_state == S_DONE), "memory written outside an execute step")
    // Once stopped, the machine stays stopped until reset.
    `MOAE_ASSERT(a_stop_sticky, i_clk, i_rst_n, r_stopped |=> r_stopped, "stopped flag cleared without reset")
    // The iterative unit finishes only while the sequencer waits for it.
    `MOAE_ASSERT(a_iter_in_wait, i_clk, i_rst_n, iter_done |-> (r_state == S_WAIT), "unit finished outside the wait step")
    // A result that reports a write carries an ok status.
    `MOAE_ASSERT(a_wrote_ok, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[2:0] == ST_OK), "write reported with an error status")

endmodule

// ----- dv/tb_memory_operand_alu_executor_top.sv -----
// ----------------------------------------------------------------------------
// tb_memory_operand_alu_executor_top
// Self-checking bench for the memory-operand ALU executor. It drives decoded
// instructions over the input stream and keeps its own copy of the data memory
// and the stop flag. Every result transfer is compared field by field with the
// oldest outcome it predicted.
// ----------------------------------------------------------------------------
module tb_memory_operand_alu_executor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import moae_pkg::*;

    localparam int MEM_WORDS = 512;

    // One decoded instruction as it travels on the input stream.
    typedef struct {
        bit [3:0]  op;
        bit [31:0] opnd_a;
        bit [31:0] opnd_b;
        bit [8:0]  dest;
        bit        a_ind;
        bit        b_ind;
    } t_instr;

    // One result as it travels on the output stream.
    typedef struct {
        bit [2:0]  status;
        bit [31:0] value;
        bit        wrote;
    } t_outcome;

    // A row of the directed table. Where 'fixed' is set, the outcome is typed
    // in by hand; otherwise the predictor supplies it.
    typedef struct {
        t_instr   ins;
        bit       fixed;
        t_outcome want;
    } t_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    // operation, operand_a, operand_b, dest_address (low bit first)
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    // a_indirect, b_indirect (low bit first)
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // status, result_value (low bit first)
    logic [M_TDATA_W-1:0] o_m_tdata;
    // wrote
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;

    // Model of the block: data memory, cleared at reset, and the stop flag.
    bit [31:0] model_mem [MEM_WORDS];
    bit        model_stopped;

    // Outcomes predicted for accepted instructions, oldest first.
    t_outcome  pending_outcomes[$];
    t_row      directed_rows[$];

    int        error_count     = 0;
    int        instrs_accepted = 0;
    // Set by the back-pressure process while the receiver refuses transfers.
    logic      rx_hold_off     = 1'b0;

    memory_operand_alu_executor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Reads a source operand. An immediate is taken as is; an indirect source
    // must name a word inside the memory, and a negative address is refused.
    function automatic bit fetch_operand(input bit [31:0] raw, input bit ind,
                                         output bit [31:0] val);
        val = raw;
        if (!ind) return 1'b1;
        if (raw[31] || raw >= MEM_WORDS) return 1'b0;
        val = model_mem[raw[8:0]];
        return 1'b1;
    endfunction

    // Executes one instruction on the model and returns the outcome it causes.
    function automatic t_outcome execute_on_model(input t_instr ins);
        t_outcome  res;
        bit [31:0] va;
        bit [31:0] vb;
        bit [31:0] r;
        bit        ok;
        longint    num;
        longint    den;
        res.status = ST_OK;
        res.value  = '0;
        res.wrote  = 1'b0;
        va = '0;
        vb = '0;
        r  = '0;
        // Once stopped, the machine only reports that it ignored the item.
        if (model_stopped) begin
            res.status = ST_STOPPED;
            return res;
        end
        case (ins.op)
            OP_TRAP: begin
                model_stopped = 1'b1;
                res.status = ST_TRAP;
                return res;
            end
            OP_EXIT, OP_END: begin
                model_stopped = 1'b1;
                res.status = ST_EXIT;
                return res;
            end
            OP_PANIC: begin
                model_stopped = 1'b1;
                res.status = ST_PANIC;
                return res;
            end
            OP_HALT: begin
                res.status = ST_HALT;
                return res;
            end
            default: ;
        endcase
        // Nop and the unused code leave everything alone.
        if (ins.op < OP_ADD || ins.op > OP_MOV) return res;

        // Address checks are made before the divisor is looked at. Not and
        // mov never read operand B, so its address cannot fault them.
        ok = fetch_operand(ins.opnd_a, ins.a_ind, va);
        if (ins.op != OP_NOT && ins.op != OP_MOV) begin
            if (!fetch_operand(ins.opnd_b, ins.b_ind, vb)) ok = 1'b0;
        end
        if (!ok || ins.dest >= MEM_WORDS) begin
            res.status = ST_BADADDR;
            return res;
        end

        case (ins.op)
            OP_ADD: r = va + vb;
            OP_SUB: r = va - vb;
            OP_MUL: r = va * vb;
            OP_DIV: begin
                if (vb == '0) begin
                    res.status = ST_DIVZERO;
                    return res;
                end
                // Wide signed division truncates toward zero; the most
                // negative value over minus one wraps back to itself.
                num = longint'($signed(va));
                den = longint'($signed(vb));
                r   = 32'(num / den);
            end
            OP_AND: r = va & vb;
            OP_OR:  r = va | vb;
            OP_XOR: r = va ^ vb;
            OP_NOT: r = ~va;
            default: r = va;
        endcase
        model_mem[ins.dest] = r;
        res.value = r;
        res.wrote = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Waits are drawn per item. Items come in bursts, and about a quarter of the
    // bursts run with no idling at all.
    function automatic int draw_gap(inout int burst_left, inout bit calm);
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 64);
            calm = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Data words lean toward the corners: zero, one, all ones and the two
    // signed extremes, small signed values and fully random words.
    function automatic bit [31:0] random_word();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            1: return 32'($signed($urandom_range(0, 31)) - 16);
            default: return $urandom;
        endcase
    endfunction

    // Nearly half of the addresses fall in a small window so that results are read
    // back often; a tenth are out of range, negative or past the last word.
    function automatic bit [31:0] random_addr();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return $urandom_range(0, 15);
        if (pick < 90) return $urandom_range(0, MEM_WORDS - 1);
        if (pick < 95) return $urandom | 32'h8000_0000;
        return $urandom_range(MEM_WORDS, 32'h7FFF_FFFF);
    endfunction

    // A well-formed instruction with random content: mostly ALU work, with
    // some nop, the unused code and halt mixed in. Stopping codes are kept for
    // the end of the run, since nothing useful can follow them.
    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)      ins.op = 4'($urandom_range(OP_ADD, OP_MOV));
        else if (pick < 89) ins.op = OP_NOP;
        else if (pick < 93) ins.op = OP_SPARE;
        else                ins.op = OP_HALT;
        ins.a_ind  = 1'($urandom_range(0, 1));
        ins.b_ind  = 1'($urandom_range(0, 1));
        ins.opnd_a = ins.a_ind ? random_addr() : random_word();
        ins.opnd_b = ins.b_ind ? random_addr() : random_word();
        if ($urandom_range(0, 1) == 0) ins.dest = 9'($urandom_range(0, 15));
        else                           ins.dest = 9'($urandom);
        return ins;
    endfunction

    task automatic add_row(input bit [3:0] op, input bit [31:0] a, input bit [31:0] b,
                           input bit [8:0] dest, input bit a_ind, input bit b_ind,
                           input bit fixed, input bit [2:0] st, input bit [31:0] val,
                           input bit wr);
        t_row row;
        row.ins.op       = op;
        row.ins.opnd_a   = a;
        row.ins.opnd_b   = b;
        row.ins.dest     = dest;
        row.ins.a_ind    = a_ind;
        row.ins.b_ind    = b_ind;
        row.fixed        = fixed;
        row.want.status  = st;
        row.want.value   = val;
        row.want.wrote   = wr;
        directed_rows.push_back(row);
    endtask

    // Sender side. Called at a rising edge. Valid is lowered only when a gap
    // is drawn, so it never falls and rises again within one edge. Returns at
    // the edge where the transfer happened and records the expected outcome.
    int send_burst = 0;
    bit send_calm  = 1'b0;

    task automatic offer_instr(input t_instr ins, input bit fixed, input t_outcome typed);
        int       gap;
        t_outcome predicted;
        gap = draw_gap(send_burst, send_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {3'b000, ins.dest, ins.opnd_b, ins.opnd_a, ins.op};
        i_s_tuser  <= {ins.b_ind, ins.a_ind};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        // The predictor always runs so that its memory stays in step with the
        // block, even where a row carries a hand-typed outcome.
        predicted = execute_on_model(ins);
        pending_outcomes.push_back(fixed ? typed : predicted);
        instrs_accepted++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random part, stopping tail, drain.
    // ------------------------------------------------------------------------
    initial begin
        t_instr   ins;
        t_outcome none;
        int       n;
        none.status = ST_OK;
        none.value  = '0;
        none.wrote  = 1'b0;

        // Directed table. Hand-typed outcomes where they are obvious from
        // the operands; indirect reads go through the predictor.
        //       op        a             b             dst  ai bi fx status      value       wr
        add_row(OP_ADD,  32'h7FFF_FFFF, 32'h0000_0001, 0,   0, 0, 1, ST_OK,      32'h8000_0000, 1);
        add_row(OP_SUB,  32'h8000_0000, 32'h0000_0001, 511, 0, 0, 1, ST_OK,      32'h7FFF_FFFF, 1);
        add_row(OP_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,   0, 0, 1, ST_OK,      32'h0000_0001, 1);
        // The most negative value over minus one wraps to itself.
        add_row(OP_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 2,   0, 0, 1, ST_OK,      32'h8000_0000, 1);
        add_row(OP_DIV,  32'h0000_0007, 32'h0000_0000, 8,   0, 0, 1, ST_DIVZERO, 32'h0, 0);
        // Truncation toward zero: -7 / 2 is -3.
        add_row(OP_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 3,   0, 0, 1, ST_OK,      32'hFFFF_FFFD, 1);
        add_row(OP_AND,  32'h0000_0000, 32'hFFFF_FFFF, 9,   1, 0, 0, ST_OK,      32'h0, 0);
        add_row(OP_OR,   32'h0000_01FF, 32'h0000_0001, 10,  1, 1, 0, ST_OK,      32'h0, 0);
        add_row(OP_XOR,  32'hA5A5_A5A5, 32'hFFFF_FFFF, 4,   0, 0, 1, ST_OK,      32'h5A5A_5A5A, 1);
        // Not ignores operand B, even an indirect one that is out of range.
        add_row(OP_NOT,  32'h0000_0000, 32'hFFFF_FFFF, 5,   0, 1, 1, ST_OK,      32'hFFFF_FFFF, 1);
        add_row(OP_MOV,  32'h0000_0002, 32'h0000_0000, 6,   1, 0, 0, ST_OK,      32'h0, 0);
        // Bad source addresses: one past the end, negative, all ones.
        add_row(OP_MOV,  32'h0000_0200, 32'h0000_0000, 17,  1, 0, 1, ST_BADADDR, 32'h0, 0);
        add_row(OP_ADD,  32'h8000_0000, 32'h0000_0000, 18,  1, 0, 1, ST_BADADDR, 32'h0, 0);
        add_row(OP_ADD,  32'h0000_0001, 32'hFFFF_FFFF, 19,  0, 1, 1, ST_BADADDR, 32'h0, 0);
        // The address check wins over a zero divisor.
        add_row(OP_DIV,  32'h0000_0258, 32'h0000_0000, 20,  1, 0, 1, ST_BADADDR, 32'h0, 0);
        // A divisor read from a word still zero since reset.
        add_row(OP_DIV,  32'h0000_0005, 32'h0000_0064, 11,  0, 1, 1, ST_DIVZERO, 32'h0, 0);
        add_row(OP_NOP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12,  1, 1, 1, ST_OK,      32'h0, 0);
        add_row(OP_SPARE, 32'h1234_5678, 32'h9ABC_DEF0, 13, 0, 0, 1, ST_OK,      32'h0, 0);
        add_row(OP_HALT, 32'h0000_0001, 32'h0000_0002, 21,  0, 0, 1, ST_HALT,    32'h0, 0);
        add_row(OP_DIV,  32'h0000_0000, 32'h0000_0003, 13,  1, 1, 0, ST_OK,      32'h0, 0);
        add_row(OP_MUL,  32'h0000_01FF, 32'h7FFF_FFFF, 14,  1, 0, 0, ST_OK,      32'h0, 0);
        add_row(OP_SUB,  32'h0000_0000, 32'h8000_0000, 7,   0, 0, 1, ST_OK,      32'h8000_0000, 1);
        add_row(OP_ADD,  32'h0000_0007, 32'h0000_000E, 15,  1, 1, 0, ST_OK,      32'h0, 0);
        add_row(OP_MOV,  32'h0000_0009, 32'hFFFF_F000, 16,  1, 1, 0, ST_OK,      32'h0, 0);

        // Reset is applied once, at the start. The block then clears its
        // memory and keeps its input ready low until that pass is over.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            offer_instr(directed_rows[k].ins, directed_rows[k].fixed, directed_rows[k].want);

        repeat (1600) offer_instr(random_instr(), 1'b0, none);

        // Stopping tail: one stopping code chosen at random, then every code
        // once and some random items, all of which the stopped machine must
        // answer as ignored.
        ins = random_instr();
        n = $urandom_range(0, 3);
        ins.op = (n == 0) ? OP_TRAP : (n == 1) ? OP_EXIT : (n == 2) ? OP_PANIC : OP_END;
        offer_instr(ins, 1'b0, none);
        for (int op = 0; op < 16; op++) begin
            ins = random_instr();
            ins.op = 4'(op);
            offer_instr(ins, 1'b0, none);
        end
        repeat (20) offer_instr(random_instr(), 1'b0, none);
        i_s_tvalid <= 1'b0;

        // Drain: wait for every predicted outcome, then give the block time to
        // show any result that should not be there.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_memory_operand_alu_executor_top OK");
        end else begin
            $display("tb_memory_operand_alu_executor_top NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, and a check of every result transfer.
    // ------------------------------------------------------------------------
    initial begin
        int       rx_wait;
        int       rx_burst;
        bit       rx_calm;
        t_outcome got;
        t_outcome want;
        rx_wait  = 0;
        rx_burst = 0;
        rx_calm  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            // Values read here are those from just before this edge.
            if (o_m_tvalid && i_m_tready) begin
                got.status = o_m_tdata[2:0];
                got.value  = o_m_tdata[34:3];
                got.wrote  = o_m_tuser[0];
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result transfer with no outcome pending: status %0d value %h wrote %0d",
                             $time, got.status, got.value, got.wrote);
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.value != want.value) begin
                        $display("%0t: result_value mismatch, expected %h, actual %h",
                                 $time, want.value, got.value);
                        error_count++;
                    end
                    if (got.wrote != want.wrote) begin
                        $display("%0t: wrote mismatch, expected %0d, actual %0d",
                                 $time, want.wrote, got.wrote);
                        error_count++;
                    end
                end
                rx_wait = draw_gap(rx_burst, rx_calm);
            end
            // Exactly one assignment to ready per edge.
            if (rx_hold_off) begin
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                i_m_tready <= 1'b0;
                rx_wait--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Back pressure: once the random part is under way, the receiver refuses
    // results for a long stretch while the sender keeps offering, so the
    // block holds its result and stalls its input.
    initial begin
        wait (instrs_accepted >= 400);
        @(posedge i_clk);
        rx_hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold_off <= 1'b0;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb_memory_operand_alu_executor_top NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/moae_pkg.sv
design/moae_ram.sv
design/moae_iter.sv
design/memory_operand_alu_executor_top.sv
dv/tb_memory_operand_alu_executor_top.sv
